### design/nidc_pkg.sv
// ----------------------------------------------------------------------------
// nidc_pkg
// Types, constants and small helper functions shared by the national
// identity number checker (length, digits, date, individual range, mod-11).
// ----------------------------------------------------------------------------
package nidc_pkg;

    localparam int unsigned ID_LEN      = 11;
    localparam int unsigned COUNT_SAT   = 12;
    localparam int unsigned DIGITS_KEPT = 9;
    localparam int unsigned WA_LEN      = 10;
    localparam int unsigned WB_LEN      = 11;
    localparam int unsigned MOD_BASE    = 11;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [6:0] MONTH_FEB = 7'd2;
    localparam logic [6:0] MONTH_DEC = 7'd12;
    localparam logic [6:0] FEB_LEAP  = 7'd29;
    localparam logic [6:0] FEB_PLAIN = 7'd28;

    localparam logic [3:0] INDIV_HUNDREDS_MIN = 4'd1;
    localparam logic [3:0] INDIV_HUNDREDS_MAX = 4'd4;

    typedef logic [3:0] t_digit;
    typedef logic [3:0] t_count;
    typedef logic [3:0] t_mod11;

    typedef enum logic [2:0] {
        FAIL_NONE     = 3'd0,
        FAIL_LENGTH   = 3'd1,
        FAIL_NONDIGIT = 3'd2,
        FAIL_DATE     = 3'd3,
        FAIL_INDIV    = 3'd4,
        FAIL_CHECK    = 3'd5
    } t_fail_reason;

    typedef struct packed {
        t_count                           count;
        logic                             nondigit;
        logic                             sum_a_zero;
        logic                             sum_b_zero;
        logic [DIGITS_KEPT-1:0][3:0]      digits;
    } t_chk;

    function automatic logic [3:0] weight_a(input t_count idx);
        logic [3:0] w;
        case (idx)
            4'd0: w = 4'd3;
            4'd1: w = 4'd7;
            4'd2: w = 4'd6;
            4'd3: w = 4'd1;
            4'd4: w = 4'd8;
            4'd5: w = 4'd9;
            4'd6: w = 4'd4;
            4'd7: w = 4'd5;
            4'd8: w = 4'd2;
            4'd9: w = 4'd1;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] weight_b(input t_count idx);
        logic [3:0] w;
        case (idx)
            4'd0:  w = 4'd5;
            4'd1:  w = 4'd4;
            4'd2:  w = 4'd3;
            4'd3:  w = 4'd2;
            4'd4:  w = 4'd7;
            4'd5:  w = 4'd6;
            4'd6:  w = 4'd5;
            4'd7:  w = 4'd4;
            4'd8:  w = 4'd3;
            4'd9:  w = 4'd2;
            4'd10: w = 4'd1;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    // Reduce a value below 128 by conditional subtraction of 88, 44, 22, 11.
    function automatic t_mod11 mod11(input logic [6:0] v);
        logic [6:0] r;
        r = v;
        if (r >= 7'(8 * MOD_BASE)) r = r - 7'(8 * MOD_BASE);
        if (r >= 7'(4 * MOD_BASE)) r = r - 7'(4 * MOD_BASE);
        if (r >= 7'(2 * MOD_BASE)) r = r - 7'(2 * MOD_BASE);
        if (r >= 7'(MOD_BASE))     r = r - 7'(MOD_BASE);
        return r[3:0];
    endfunction

    function automatic logic [6:0] month_days(input logic [6:0] month);
        logic [6:0] d;
        case (month)
            7'd1:  d = 7'd31;
            7'd3:  d = 7'd31;
            7'd4:  d = 7'd30;
            7'd5:  d = 7'd31;
            7'd6:  d = 7'd30;
            7'd7:  d = 7'd31;
            7'd8:  d = 7'd31;
            7'd9:  d = 7'd30;
            7'd10: d = 7'd31;
            7'd11: d = 7'd30;
            7'd12: d = 7'd31;
            default: d = 7'd0;
        endcase
        return d;
    endfunction

endpackage

### design/nidc_if.sv
// ----------------------------------------------------------------------------
// nidc_if
// Valid/ready channels of the identity number checker: character stream in,
// verdict out.
// ----------------------------------------------------------------------------
interface nidc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface nidc_out_if;
    logic       valid;
    logic       ready;
    logic       id_valid;
    logic [2:0] fail_reason;

    modport source (output valid, output id_valid, output fail_reason, input ready);
    modport sink   (input valid, input id_valid, input fail_reason, output ready);
endinterface

### design/nidc_accum.sv
// ----------------------------------------------------------------------------
// nidc_accum
// Per-character state: count, nondigit flag, first nine digits and running
// mod-11 weighted sums. Presents the state as it stands after the current
// character.
// ----------------------------------------------------------------------------
module nidc_accum
    import nidc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_char,
    input  logic       i_last,
    output t_chk       o_chk
);

    t_count r_count;
    t_count n_count;
    logic   r_nondigit;
    logic   n_nondigit;
    t_mod11 r_sa;
    t_mod11 n_sa;
    t_mod11 r_sb;
    t_mod11 n_sb;
    t_digit r_digits [DIGITS_KEPT];

    logic   is_digit;
    t_digit digit;
    logic   store;

    always_comb begin
        is_digit = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
        digit    = is_digit ? i_char[3:0] : '0;
        store    = r_count < t_count'(ID_LEN);

        n_count    = (r_count < t_count'(COUNT_SAT)) ? r_count + 4'd1 : r_count;
        n_nondigit = r_nondigit | (store & ~is_digit);

        if (r_count < t_count'(WA_LEN)) begin
            n_sa = mod11(7'(r_sa) + 7'(8'(weight_a(r_count)) * 8'(digit)));
        end else begin
            n_sa = r_sa;
        end
        if (r_count < t_count'(WB_LEN)) begin
            n_sb = mod11(7'(r_sb) + 7'(8'(weight_b(r_count)) * 8'(digit)));
        end else begin
            n_sb = r_sb;
        end

        o_chk.count      = n_count;
        o_chk.nondigit   = n_nondigit;
        o_chk.sum_a_zero = (n_sa == '0);
        o_chk.sum_b_zero = (n_sb == '0);
        for (int i = 0; i < DIGITS_KEPT; i++) begin
            o_chk.digits[i] = r_digits[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_nondigit <= 1'b0;
            r_sa       <= '0;
            r_sb       <= '0;
        end else if (i_fire) begin
            if (i_last) begin
                r_count    <= '0;
                r_nondigit <= 1'b0;
                r_sa       <= '0;
                r_sb       <= '0;
            end else begin
                r_count    <= n_count;
                r_nondigit <= n_nondigit;
                r_sa       <= n_sa;
                r_sb       <= n_sb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && (r_count < t_count'(DIGITS_KEPT))) begin
            r_digits[r_count] <= digit;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(COUNT_SAT))
        else $error("character count beyond saturation");

    a_sums_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sa < t_mod11'(MOD_BASE)) && (r_sb < t_mod11'(MOD_BASE)))
        else $error("running check sum not reduced mod 11");

    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_last |=> (r_count == '0) && !r_nondigit && (r_sa == '0) && (r_sb == '0))
        else $error("state not cleared after last character");

endmodule

### design/nidc_verdict.sv
// ----------------------------------------------------------------------------
// nidc_verdict
// Ordered checks on the state after the last character: length, digits,
// birth date, individual number range, mod-11 check digits.
// ----------------------------------------------------------------------------
module nidc_verdict
    import nidc_pkg::*;
(
    input  t_chk         i_chk,
    output t_fail_reason o_reason
);

    logic [6:0] day;
    logic [6:0] month;
    logic [6:0] yy;
    logic [6:0] limit;
    logic       leap;
    logic       date_ok;
    logic       indiv_ok;

    always_comb begin
        day   = 7'(i_chk.digits[0]) * 7'd10 + 7'(i_chk.digits[1]);
        month = 7'(i_chk.digits[2]) * 7'd10 + 7'(i_chk.digits[3]);
        yy    = 7'(i_chk.digits[4]) * 7'd10 + 7'(i_chk.digits[5]);
        leap  = (yy[1:0] == 2'b00) && (yy != '0);

        if (month == MONTH_FEB) begin
            limit = leap ? FEB_LEAP : FEB_PLAIN;
        end else begin
            limit = month_days(month);
        end

        date_ok  = (month >= 7'd1) && (month <= MONTH_DEC)
                && (day >= 7'd1) && (day <= limit);
        indiv_ok = (i_chk.digits[6] >= INDIV_HUNDREDS_MIN)
                && (i_chk.digits[6] <= INDIV_HUNDREDS_MAX);

        if (i_chk.count != t_count'(ID_LEN)) begin
            o_reason = FAIL_LENGTH;
        end else if (i_chk.nondigit) begin
            o_reason = FAIL_NONDIGIT;
        end else if (!date_ok) begin
            o_reason = FAIL_DATE;
        end else if (!indiv_ok) begin
            o_reason = FAIL_INDIV;
        end else if (!(i_chk.sum_a_zero && i_chk.sum_b_zero)) begin
            o_reason = FAIL_CHECK;
        end else begin
            o_reason = FAIL_NONE;
        end
    end

endmodule

### design/national_id_number_checker_core.sv
// The verdict is registered: the last character passes the input register, then the verdict register.
// Throughput: one character per cycle; the input register feeds the running-sum
// state and, on a last character, the verdict register.
// A waiting verdict stalls only a following last character.
// Reset: synchronous, active low; clears the count, flags, sums and valids.
// ----------------------------------------------------------------------------
// national_id_number_checker_core
// Streams ASCII characters of an identity number and reports one verdict
// per string: valid, or the first failing check.
// ----------------------------------------------------------------------------
module national_id_number_checker_core
    import nidc_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    nidc_in_if.sink        i_item,
    nidc_out_if.source     o_result
);

    logic         r_in_valid;
    logic [7:0]   r_in_char;
    logic         r_in_last;
    logic         r_out_valid;
    t_fail_reason r_out_reason;
    logic         r_out_id_valid;

    logic         proc_fire;
    t_chk         chk;
    t_fail_reason reason;

    assign proc_fire    = r_in_valid && (!r_in_last || !r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || proc_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_char <= i_item.char_code;
            r_in_last <= i_item.last_char;
        end
    end

    nidc_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (proc_fire),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_chk   (chk)
    );

    nidc_verdict u_verdict (
        .i_chk    (chk),
        .o_reason (reason)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && r_in_last) begin
            r_out_reason   <= reason;
            r_out_id_valid <= (reason == FAIL_NONE);
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.id_valid    = r_out_id_valid;
    assign o_result.fail_reason = r_out_reason;

    a_verdict_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_id_valid == (r_out_reason == FAIL_NONE)))
        else $error("id_valid disagrees with fail_reason");

    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_last && r_out_valid && !o_result.ready
        |=> r_in_valid && r_in_last)
        else $error("last character dropped while verdict pending");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc_fire && r_in_last |=> r_out_valid)
        else $error("no verdict after processing last character");

endmodule
